@@ rtl/open_addressing_hash_table_defines.svh @@
// Assertion macros for the open addressing hash table
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OAHT_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAHT_ASSERT(label, clk, rst_n, prop, msg)
`define OAHT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/oaht_pkg.sv @@
// Shared types, constants and helpers for the open addressing hash table
package oaht_pkg;
	localparam int MAX_SLOTS = 64;
	localparam int KEY_BYTES = 8;
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int SIZE_W = 7;
	localparam int SUM_W = 11;
	localparam int HASH_W = SUM_W + 5;
	localparam logic [4:0] HASH_MULT = 5'd31;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [62:0] key;
		logic [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [5:0]  slot_index;
	} out_word_t;

	typedef struct packed {
		logic [1:0]        req;
		logic [63:0]       key;
		logic [31:0]       value;
		logic [SUM_W-1:0]  sum;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MOD,
		BK_HOME,
		BK_SCAN,
		BK_DONE
	} bk_state_t;
endpackage

@@ rtl/oaht_front.sv @@
// Front: normalises the key, sums its bytes and queues the job
module oaht_front import oaht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t in_word,
	output logic     job_valid,
	input  logic     job_take,
	output job_t     job
);
	localparam int DEPTH = 2;
	job_t        q_q [DEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	job_t        nj;
	logic        stop;
	logic [63:0] raw;

	assign raw = {1'b0, in_word.key};

	always_comb begin
		nj.req = in_word.req_type;
		nj.value = in_word.value;
		nj.key = '0;
		nj.sum = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (!stop && raw[8*i +: 8] != 8'd0) begin
				nj.key[8*i +: 8] = raw[8*i +: 8];
				nj.sum = nj.sum + SUM_W'(raw[8*i +: 8]);
			end else begin
				stop = 1'b1;
			end
		end
	end

	assign full = (cnt_q == 2'(DEPTH));
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) q_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (job_take && job_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(job_take && job_valid);
		end
	end
endmodule

@@ rtl/oaht_back.sv @@
// Back: reduces the hash, scans the slots and writes the table
module oaht_back import oaht_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [SIZE_W-1:0] table_size,
	input  logic            job_valid,
	output logic            job_take,
	input  job_t            job,
	output logic            res_valid,
	input  logic            res_take,
	output out_word_t       res
);
	logic [63:0]        key_mem [MAX_SLOTS];
	logic [31:0]        val_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] valid_q;
	logic [SIZE_W-1:0]  count_q;
	bk_state_t          st_q, st_d;
	job_t               job_q;
	logic [HASH_W-1:0]  rem_q;
	logic [SIZE_W-1:0]  n_q;
	logic [SLOT_W-1:0]  home_q, idx_q, rd_addr;
	logic               back_q;
	logic [63:0]        rkey_q;
	logic [31:0]        rval_q;
	logic               res_valid_q;
	out_word_t          res_q;
	logic               wr_en, clr_en, fin;
	logic [SLOT_W-1:0]  wr_addr;
	logic [SLOT_W-1:0]  nxt_idx;
	logic               nxt_back, nxt_end;
	out_word_t          fin_res;
	logic               cur_valid, hit, isfree;
	logic [SIZE_W-1:0]  n_eff;

	always_comb begin
		if (table_size == '0) n_eff = SIZE_W'(1);
		else if (table_size > SIZE_W'(MAX_SLOTS)) n_eff = SIZE_W'(MAX_SLOTS);
		else n_eff = table_size;
	end

	assign cur_valid = valid_q[idx_q];
	assign hit = cur_valid && rkey_q == job_q.key;
	assign isfree = !cur_valid;

	always_comb begin
		nxt_back = back_q;
		nxt_idx = idx_q;
		nxt_end = 1'b0;
		if (!back_q) begin
			if ({1'b0, idx_q} + 7'd1 < n_q) nxt_idx = idx_q + SLOT_W'(1);
			else if (home_q != '0) begin
				nxt_back = 1'b1;
				nxt_idx = home_q - SLOT_W'(1);
			end else nxt_end = 1'b1;
		end else begin
			if (idx_q != '0) nxt_idx = idx_q - SLOT_W'(1);
			else nxt_end = 1'b1;
		end
	end

	assign rd_addr = (st_q == BK_MOD) ? SLOT_W'(rem_q) : nxt_idx;

	always_comb begin
		st_d = st_q;
		job_take = 1'b0;
		wr_en = 1'b0;
		clr_en = 1'b0;
		wr_addr = idx_q;
		fin = 1'b0;
		fin_res = '0;
		fin_res.status = ST_NOTFOUND;
		case (st_q)
			BK_IDLE: begin
				if (job_valid && !res_valid_q) begin
					job_take = 1'b1;
					st_d = BK_MOD;
				end
			end
			BK_MOD: begin
				if (rem_q < HASH_W'(n_q)) st_d = BK_HOME;
			end
			BK_HOME: begin
				st_d = BK_SCAN;
				case (job_q.req)
					REQ_LOOKUP, REQ_REMOVE: begin
						if (!cur_valid) fin = 1'b1;
						else if (hit) begin
							fin = 1'b1;
							fin_res.status = ST_OK;
							fin_res.slot_index = 6'(idx_q);
							if (job_q.req == REQ_LOOKUP) fin_res.value_out = rval_q;
							else clr_en = 1'b1;
						end else if (nxt_end) fin = 1'b1;
					end
					REQ_INSERT: begin
						if (job_q.value == '0 || count_q + 7'd1 > n_q) begin
							fin = 1'b1;
							fin_res.status = ST_REJECT;
						end else if (!cur_valid || hit) begin
							fin = 1'b1;
							wr_en = 1'b1;
							fin_res.status = ST_OK;
							fin_res.slot_index = 6'(idx_q);
						end else if (nxt_end) fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			BK_SCAN: begin
				if (job_q.req == REQ_INSERT) begin
					if (isfree) begin
						fin = 1'b1;
						wr_en = 1'b1;
						fin_res.status = ST_OK;
						fin_res.slot_index = 6'(idx_q);
					end else if (nxt_end) fin = 1'b1;
				end else begin
					if (hit) begin
						fin = 1'b1;
						fin_res.status = ST_OK;
						fin_res.slot_index = 6'(idx_q);
						if (job_q.req == REQ_LOOKUP) fin_res.value_out = rval_q;
						else clr_en = 1'b1;
					end else if (nxt_end) fin = 1'b1;
				end
			end
			default: st_d = BK_IDLE;
		endcase
		if (fin) st_d = BK_IDLE;
	end

	always_ff @(posedge clk) begin
		rkey_q <= key_mem[rd_addr];
		rval_q <= val_mem[rd_addr];
		if (wr_en) begin
			key_mem[wr_addr] <= job_q.key;
			val_mem[wr_addr] <= job_q.value;
		end
		if (job_take) begin
			job_q <= job;
			n_q <= n_eff;
			rem_q <= HASH_W'(job.sum) * HASH_W'(HASH_MULT);
		end else if (st_q == BK_MOD) begin
			if (rem_q >= (HASH_W'(n_q) << 6)) rem_q <= rem_q - (HASH_W'(n_q) << 6);
			else if (rem_q >= HASH_W'(n_q)) rem_q <= rem_q - HASH_W'(n_q);
			home_q <= SLOT_W'(rem_q);
			idx_q <= SLOT_W'(rem_q);
			back_q <= 1'b0;
		end else if (st_q == BK_HOME || st_q == BK_SCAN) begin
			idx_q <= nxt_idx;
			back_q <= nxt_back;
		end
		if (fin) res_q <= fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			valid_q <= '0;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (wr_en && !valid_q[wr_addr]) begin
				valid_q[wr_addr] <= 1'b1;
				count_q <= count_q + SIZE_W'(1);
			end
			if (clr_en) begin
				valid_q[wr_addr] <= 1'b0;
				if (count_q != '0) count_q <= count_q - SIZE_W'(1);
			end
			if (fin) res_valid_q <= 1'b1;
			else if (res_take) res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
endmodule

@@ rtl/open_addressing_hash_table.sv @@
// Top level of the open addressing hash table
// channel | direction | handshake      | word
// request | in        | push / full    | in_word (req_type, key, value)
// result  | out       | pop / empty    | out_word (status, value_out, slot_index)
// config  | in        | cfg_valid/ready| cfg_data (table_size)
// The hash is reduced by taking 64 n or n off per cycle, slowest at small sizes, then one
// slot is read a cycle over the probe scan from the block RAM port.
// Reset clears slot valid bits, the count and table_size (64) at once; no clearing pass.
// Two request words queue in front; the back stalls only while its result is unread.
`include "open_addressing_hash_table_defines.svh"
module open_addressing_hash_table import oaht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_word_t    in_word,
	output logic        empty,
	input  logic        pop,
	output out_word_t   out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	logic [SIZE_W-1:0] size_q;
	logic              job_valid, job_take, res_valid;
	job_t              job;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SIZE_RESET;
		else if (cfg_valid && cfg_ready) size_q <= cfg_data;
	end

	oaht_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.job_valid, .job_take, .job
	);

	oaht_back u_back (
		.clk, .arst_n, .table_size(size_q),
		.job_valid, .job_take, .job,
		.res_valid, .res_take(pop), .res(out_word)
	);

	assign empty = !res_valid;

	`OAHT_ASSERT(a_ok_slot, clk, arst_n, (!empty && out_word.status != ST_OK) |-> (out_word.slot_index == 6'd0), "slot on miss")
	`OAHT_ASSERT(a_val_ok, clk, arst_n, (!empty && out_word.value_out != 32'd0) |-> (out_word.status == ST_OK), "value on miss")
	`OAHT_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> !empty, "result lost")
endmodule

@@ dv/tb_open_addressing_hash_table.sv @@
// Testbench for the open addressing hash table: predicted lookups, inserts and removes
`timescale 1ns / 1ps
module tb_open_addressing_hash_table;
	import oaht_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_word_t in_word = '0;
	logic empty;
	logic pop = 1'b0;
	out_word_t out_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;

	open_addressing_hash_table DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [6:0]  size_reg;
	logic        tbl_valid [MAX_SLOTS];
	logic [63:0] tbl_key [MAX_SLOTS];
	logic [31:0] tbl_value [MAX_SLOTS];
	int unsigned tbl_count;

	out_word_t pending_results [$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_pop = 0;
	int quiet = 0;
	int n_sent = 0;
	int n_checked = 0;
	logic [62:0] key_pool [16];

	function automatic int unsigned table_slots();
		if (size_reg == 0) return 1;
		if (size_reg > MAX_SLOTS) return MAX_SLOTS;
		return size_reg;
	endfunction

	function automatic logic [63:0] clip_key(logic [62:0] raw, output int unsigned sum);
		logic [63:0] k;
		logic [7:0] b;
		k = '0;
		sum = 0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			b = 8'(raw >> (8 * i));
			if (b == 0) break;
			k |= 64'(b) << (8 * i);
			sum += b;
		end
		return k;
	endfunction

	function automatic bit hunt_key(int unsigned h, int unsigned n, logic [63:0] k,
		output int unsigned at);
		at = 0;
		if (!tbl_valid[h]) return 0;
		if (tbl_key[h] == k) begin
			at = h;
			return 1;
		end
		for (int unsigned i = h + 1; i < n; i++)
			if (tbl_valid[i] && tbl_key[i] == k) begin
				at = i;
				return 1;
			end
		for (int i = int'(h) - 1; i >= 0; i--)
			if (tbl_valid[i] && tbl_key[i] == k) begin
				at = i;
				return 1;
			end
		return 0;
	endfunction

	function automatic bit hunt_free(int unsigned h, int unsigned n, output int unsigned at);
		at = h;
		for (int unsigned i = h + 1; i < n; i++)
			if (!tbl_valid[i]) begin
				at = i;
				return 1;
			end
		for (int i = int'(h) - 1; i >= 0; i--)
			if (!tbl_valid[i]) begin
				at = i;
				return 1;
			end
		return 0;
	endfunction

	function automatic out_word_t serve_request(in_word_t w);
		out_word_t r;
		int unsigned n, sum, h, at;
		logic [63:0] k;
		bit ok;
		r = '0;
		r.status = ST_NOTFOUND;
		n = table_slots();
		k = clip_key(w.key, sum);
		h = (sum * 31) % n;
		case (req_t'(w.req_type))
			REQ_LOOKUP: begin
				if (hunt_key(h, n, k, at)) begin
					r.status = ST_OK;
					r.value_out = tbl_value[at];
					r.slot_index = at[5:0];
				end
			end
			REQ_INSERT: begin
				if (w.value == 0 || tbl_count + 1 > n) begin
					r.status = ST_REJECT;
				end else if (tbl_valid[h] && tbl_key[h] == k) begin
					tbl_value[h] = w.value;
					r.status = ST_OK;
					r.slot_index = h[5:0];
				end else begin
					ok = 1;
					at = h;
					if (tbl_valid[h]) ok = hunt_free(h, n, at);
					if (ok) begin
						tbl_valid[at] = 1'b1;
						tbl_key[at] = k;
						tbl_value[at] = w.value;
						tbl_count = (tbl_count + 1) & 7'h7f;
						r.status = ST_OK;
						r.slot_index = at[5:0];
					end
				end
			end
			REQ_REMOVE: begin
				if (hunt_key(h, n, k, at)) begin
					tbl_valid[at] = 1'b0;
					if (tbl_count > 0) tbl_count--;
					r.status = ST_OK;
					r.slot_index = at[5:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(logic [1:0] rt, logic [62:0] k, logic [31:0] v);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		in_word <= '{req_type: rt, key: k, value: v};
		push <= 1'b1;
		do @(posedge clk); while (full);
		pending_results.push_back(serve_request('{req_type: rt, key: k, value: v}));
		n_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_size(logic [6:0] s);
		drain();
		cfg_data <= s;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = s;
	endtask

	function automatic logic [62:0] rand_key();
		logic [62:0] k;
		int unsigned len;
		case ($urandom_range(3))
			0: k = 63'({$urandom, $urandom});
			1: k = key_pool[$urandom_range(15)];
			default: begin
				len = $urandom_range(1, 8);
				k = '0;
				for (int i = 0; i < len && i < 7; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
				if (len == 8) k[62:56] = 7'($urandom_range(1, 127));
			end
		endcase
		return k;
	endfunction

	task automatic random_requests(int count);
		logic [1:0] rt;
		for (int i = 0; i < count; i++) begin
			rt = ($urandom_range(19) == 0) ? REQ_NONE : 2'($urandom_range(2));
			send_request(rt, rand_key(), ($urandom_range(9) == 0) ? 32'd0 : $urandom);
		end
	endtask

	task automatic test_directed();
		send_request(REQ_LOOKUP, 63'h41, 32'd5);
		send_request(REQ_REMOVE, 63'h41, 32'd0);
		send_request(REQ_INSERT, 63'h41, 32'd0);
		send_request(REQ_INSERT, 63'h41, 32'hffffffff);
		send_request(REQ_INSERT, 63'h41, 32'd1);
		send_request(REQ_LOOKUP, 63'h41, 32'd0);
		send_request(REQ_INSERT, 63'h4142, 32'd7);
		send_request(REQ_INSERT, 63'h4241, 32'd8);
		send_request(REQ_LOOKUP, 63'h4241, 32'd0);
		send_request(REQ_INSERT, 63'h7fff_ffff_ffff_ffff, 32'd9);
		send_request(REQ_LOOKUP, 63'h00ff_ffff_ffff_ffff, 32'd0);
		send_request(REQ_INSERT, 63'h4100_4242, 32'd3);
		send_request(REQ_LOOKUP, 63'h42, 32'd0);
		send_request(REQ_LOOKUP, 63'h0, 32'd0);
		send_request(REQ_INSERT, 63'h0, 32'd11);
		send_request(REQ_REMOVE, 63'h4142, 32'd0);
		send_request(REQ_LOOKUP, 63'h4241, 32'd0);
		send_request(REQ_NONE, 63'h41, 32'd4);
		send_request(REQ_REMOVE, 63'h4241, 32'd0);
	endtask

	task automatic test_tiny_tables();
		write_size(7'd0);
		send_request(REQ_INSERT, 63'h61, 32'd1);
		send_request(REQ_INSERT, 63'h62, 32'd2);
		send_request(REQ_LOOKUP, 63'h62, 32'd0);
		write_size(7'd2);
		random_requests(60);
		write_size(7'd5);
		random_requests(80);
		write_size(7'd1);
		random_requests(30);
	endtask

	task automatic test_backpressure();
		hold_pop = 300;
		random_requests(12);
	endtask

	initial begin
		bit fail;
		for (int i = 0; i < 16; i++) key_pool[i] = 63'({$urandom, $urandom} & {8{8'($urandom_range(3) ? 8'hff : 8'h7f)}});
		size_reg = SIZE_RESET;
		tbl_count = 0;
		for (int i = 0; i < MAX_SLOTS; i++) tbl_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle = 24;
		recv_idle = 74;
		test_tiny_tables();
		write_size(7'd64);
		random_requests(300);
		send_idle = 74;
		recv_idle = 24;
		write_size(7'd127);
		random_requests(200);
		write_size(7'd16);
		random_requests(150);
		send_idle = 0;
		recv_idle = 0;
		test_backpressure();
		write_size(7'd40);
		random_requests(180);
		drain();
		$display("covered %0d requests over table sizes 0 to 127, incl. a long result stall",
			n_sent);
		$display("results checked: %0d", n_checked);
		fail = errors != 0 || pending_results.size() != 0;
		if (!fail) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		out_word_t want;
		if (pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (out_word.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, out_word.status);
					errors++;
				end
				if (out_word.value_out !== want.value_out) begin
					$error("value_out expected %h actual %h", want.value_out,
						out_word.value_out);
					errors++;
				end
				if (out_word.slot_index !== want.slot_index) begin
					$error("slot_index expected %0d actual %0d", want.slot_index,
						out_word.slot_index);
					errors++;
				end
			end
		end
		if (hold_pop > 0) begin
			hold_pop <= hold_pop - 1;
			pop <= 1'b0;
		end else begin
			pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || hold_pop > 0 || cfg_valid) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("watchdog: no progress");
			$display("end of test: mismatches");
			$finish;
		end
	end
endmodule
